FILE: src/sbh_pkg.sv
// Shared types and constants for the string bucket hash core.
package sbh_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int ACC_W   = 32;
    localparam int TSIZE_W = 16;
    localparam int REM_W   = 20;   // holds any remainder below the hash prime

    // Serial divider sequencing: one quotient bit per step over the full dividend
    localparam int NUM_STEPS = ACC_W;
    localparam int CNT_W     = $clog2(NUM_STEPS);

    // Hash constants
    localparam int ROT_R = 5;
    localparam logic [REM_W-1:0]   HASH_PRIME  = REM_W'(899981);
    localparam logic [REM_W-1:0]   HASH_OFFSET = REM_W'(100000);
    localparam logic [TSIZE_W-1:0] TSIZE_RESET = TSIZE_W'(256);

    // 2**REM_W mod the hash prime: weight of the bits above the fold point
    localparam logic [REM_W-1:0]   FOLD_MUL    = REM_W'(148595);

    // Controller to datapath commands
    typedef struct packed {
        logic absorb;     // fold the input byte into the accumulator
        logic load_p1;    // start reduction by the hash prime
        logic fold;       // one multiply-fold of the upper bits
        logic load_p2;    // start reduction by the table size
        logic step;       // one restoring-division step
        logic load_out;   // move the remainder to the output register
    } t_sbh_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic key_end;    // input byte is the terminator
        logic fold_done;  // nothing left above the fold point
        logic out_free;   // output register can take a new word
    } t_sbh_stat;

endpackage

FILE: src/string_bucket_hash_core.sv
// Top level of the string bucket hash core.
// A nonzero key byte is absorbed as it is taken; the next byte can follow at once.
// A zero byte runs a multiply-fold by the hash prime, repeated while the key
// hash leaves bits above the fold point, and a serial modulo by the table size:
// the bucket word loads once the output register is free; input is held off until then.
// Synchronous active-low reset clears the accumulator and sets table size 256.
module string_bucket_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,     // [7:0] key_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,     // [15:0] bucket_index
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data  // table_size
);

    sbh_pkg::t_sbh_cmd  s_cmd;
    sbh_pkg::t_sbh_stat s_stat;

    sbh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    sbh_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_key_byte     (i_s_tdata),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_bucket_index (o_m_tdata),
        .i_cmd          (s_cmd),
        .o_stat         (s_stat)
    );

endmodule

FILE: src/sbh_ctrl.sv
// Controller state machine that sequences absorb and the two modulo passes.
module sbh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  sbh_pkg::t_sbh_stat i_stat,
    output sbh_pkg::t_sbh_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD1  = 3'd1;
    localparam logic [2:0] S_LOAD2 = 3'd2;
    localparam logic [2:0] S_MOD2  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                r_state, n_state;
    logic [sbh_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      s_acc;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (i_stat.key_end) begin
                        o_cmd.load_p1 = 1'b1;
                        n_state       = S_MOD1;
                    end else begin
                        o_cmd.absorb = 1'b1;
                    end
                end
            end
            S_MOD1: begin
                // fold until the upper bits are gone
                if (i_stat.fold_done) begin
                    n_state = S_LOAD2;
                end else begin
                    o_cmd.fold = 1'b1;
                end
            end
            S_LOAD2: begin
                o_cmd.load_p2 = 1'b1;
                n_cnt         = sbh_pkg::CNT_W'(sbh_pkg::NUM_STEPS - 1);
                n_state       = S_MOD2;
            end
            S_MOD2: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output register to drain
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: src/sbh_dp.sv
// Datapath: hash accumulator, prime fold, serial restoring divider and output register.
module sbh_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sbh_pkg::BYTE_W-1:0]    i_key_byte,
    input  logic                          i_cfg_wr_en,
    input  logic [sbh_pkg::TSIZE_W-1:0]   i_cfg_wr_data,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [sbh_pkg::TSIZE_W-1:0]   o_bucket_index,
    input  sbh_pkg::t_sbh_cmd             i_cmd,
    output sbh_pkg::t_sbh_stat            o_stat
);

    localparam int AW = sbh_pkg::ACC_W;
    localparam int RW = sbh_pkg::REM_W;
    localparam int TW = sbh_pkg::TSIZE_W;

    logic [AW-1:0] r_acc;
    logic [AW-1:0] r_dvd;
    logic [RW-1:0] r_rem;
    logic [RW-1:0] r_div;
    logic [TW-1:0] r_tsize;
    logic [TW-1:0] r_out;
    logic          r_out_valid;

    logic [RW:0]   s_trial;
    logic [RW:0]   s_diff;
    logic [RW-1:0] s_red;
    logic [RW-1:0] s_folded;
    logic [AW-1:0] s_fold;
    logic [AW-1:0] s_rot;

    // Rotate right, then the byte is added
    assign s_rot = {r_acc[sbh_pkg::ROT_R-1:0], r_acc[AW-1:sbh_pkg::ROT_R]};

    // Prime fold: upper bits times (2**RW mod prime) added to the lower bits
    assign s_fold = {{(AW-RW){1'b0}}, r_dvd[RW-1:0]}
                  + ({{RW{1'b0}}, r_dvd[AW-1:RW]}
                     * {{(AW-RW){1'b0}}, sbh_pkg::FOLD_MUL});

    // Below 2**RW one compare-subtract finishes the prime remainder
    assign s_red = (r_dvd[RW-1:0] >= sbh_pkg::HASH_PRIME) ?
                   (r_dvd[RW-1:0] - sbh_pkg::HASH_PRIME) : r_dvd[RW-1:0];

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign s_trial  = {r_rem, r_dvd[AW-1]};
    assign s_diff   = s_trial - {1'b0, r_div};
    assign s_folded = s_red + sbh_pkg::HASH_OFFSET;

    assign o_stat.key_end   = (i_key_byte == '0);
    assign o_stat.fold_done = (r_dvd[AW-1:RW] == '0);
    assign o_stat.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid     = r_out_valid;
    assign o_bucket_index = r_out;

    // Control state: accumulator, table size, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_tsize     <= sbh_pkg::TSIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tsize <= i_cfg_wr_data;
            end
            if (i_cmd.absorb) begin
                r_acc <= s_rot + {{(AW-sbh_pkg::BYTE_W){1'b0}}, i_key_byte};
            end else if (i_cmd.load_p1) begin
                r_acc <= '0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Prime fold, divider and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_p1) begin
            r_dvd <= r_acc;
        end else if (i_cmd.fold) begin
            r_dvd <= s_fold;
        end else if (i_cmd.load_p2) begin
            r_dvd <= {{(AW-RW){1'b0}}, s_folded};
            r_rem <= '0;
            r_div <= {{(RW-TW){1'b0}}, r_tsize};
        end else if (i_cmd.step) begin
            r_dvd <= {r_dvd[AW-2:0], 1'b0};
            r_rem <= s_diff[RW] ? s_trial[RW-1:0] : s_diff[RW-1:0];
        end
        if (i_cmd.load_out) begin
            // zero table size has no meaning; report bucket 0
            r_out <= (r_tsize == '0) ? '0 : r_rem[TW-1:0];
        end
    end

endmodule

FILE: src/sbh_checker.sv
// Port-level assertions for the string bucket hash core, with bind.
module sbh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        i_cfg_wr_en,
    input logic [15:0] i_cfg_wr_data
);

    logic [15:0] r_tsize;
    logic        s_term;

    assign s_term = i_s_tvalid && o_s_tready && (i_s_tdata == 8'd0);

    // Mirror of the table size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsize <= sbh_pkg::TSIZE_RESET;
        end else if (i_cfg_wr_en) begin
            r_tsize <= i_cfg_wr_data;
        end
    end

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed while stalled");

    // Input is held off right after a terminator
    a_term_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_term |=> !o_s_tready)
        else $error("input ready right after terminator");

    // Still busy well into the modulo passes
    a_term_busy_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_term |-> ##34 !o_s_tready)
        else $error("input ready during modulo passes");

    // Bucket below table size whenever the table size is nonzero
    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (r_tsize != 16'd0) |-> o_m_tdata < r_tsize)
        else $error("bucket index not below table size");

endmodule

bind string_bucket_hash_core sbh_checker u_sbh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_s_tvalid    (i_s_tvalid),
    .o_s_tready    (o_s_tready),
    .i_s_tdata     (i_s_tdata),
    .o_m_tvalid    (o_m_tvalid),
    .i_m_tready    (i_m_tready),
    .o_m_tdata     (o_m_tdata),
    .i_cfg_wr_en   (i_cfg_wr_en),
    .i_cfg_wr_data (i_cfg_wr_data)
);

FILE: verif/sbh_bucket_checker.sv
// Bus monitor, bucket predictor and scoreboard for the string bucket hash core.
`timescale 1ns / 100ps

module sbh_bucket_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,     // [7:0] key_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,     // [15:0] bucket_index
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data, // table_size
    output int          o_fail_count,
    output int          o_pending
);

    localparam int REPORT_MAX = 10;
    localparam int AW = sbh_pkg::ACC_W;
    localparam int BW = sbh_pkg::BYTE_W;
    localparam int TW = sbh_pkg::TSIZE_W;

    // Predictor state: running key hash and current bucket count
    logic [AW-1:0]      key_hash;
    logic [TW-1:0]      bucket_count;
    logic [15:0]        bucket_expect_q[$];
    int                 fail_count;

    // Rotate right by 5, then add the key byte (wraps at 32 bits)
    function automatic logic [AW-1:0] fold_key_byte(input logic [AW-1:0] h,
                                                    input logic [BW-1:0] b);
        return {h[sbh_pkg::ROT_R-1:0], h[AW-1:sbh_pkg::ROT_R]} + AW'(b);
    endfunction

    // Reduce by the hash prime, add the offset, then reduce by the bucket count
    function automatic logic [15:0] bucket_for(input logic [AW-1:0] h,
                                               input logic [TW-1:0] buckets);
        logic [31:0] folded;
        folded = (h % 32'(sbh_pkg::HASH_PRIME)) + 32'(sbh_pkg::HASH_OFFSET);
        if (buckets == '0)
            return 16'd0;   // zero bucket count gives bucket 0
        return 16'(folded % 32'(buckets));
    endfunction

    task automatic note_failure();
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_hash     = '0;
            bucket_count = sbh_pkg::TSIZE_RESET;
            bucket_expect_q.delete();
            fail_count   = 0;
        end else begin
            // Register write
            if (i_cfg_wr_en)
                bucket_count = i_cfg_wr_data;

            // Input word: absorb, or finish the key
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tdata != 8'd0) begin
                    key_hash = fold_key_byte(key_hash, i_s_tdata);
                end else begin
                    bucket_expect_q.push_back(bucket_for(key_hash, bucket_count));
                    key_hash = '0;
                end
            end

            // Output word against the oldest expectation
            if (i_m_tvalid && i_m_tready) begin
                if (bucket_expect_q.size() == 0) begin
                    if (fail_count < REPORT_MAX)
                        $display("[%0t] unexpected bucket word %0d", $realtime, i_m_tdata);
                    note_failure();
                end else begin
                    if (i_m_tdata !== bucket_expect_q[0]) begin
                        if (fail_count < REPORT_MAX)
                            $display("[%0t] bucket mismatch: expected %0d, got %0d",
                                     $realtime, bucket_expect_q[0], i_m_tdata);
                        note_failure();
                    end
                    void'(bucket_expect_q.pop_front());
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= bucket_expect_q.size();
    end

endmodule

FILE: verif/testbench.sv
// Stimulus, reset, verdict and timeout for the string bucket hash core.
`timescale 1ns / 100ps

module testbench;

    localparam logic [7:0] KEY_END     = 8'h00;
    localparam int         RANDOM_ITEMS = 1900;
    localparam int         LONG_HOLD   = 300;
    localparam int         SETTLE      = 8;
    localparam int         DRAIN_WAIT  = 100;
    localparam int         CYCLE_LIMIT = 1000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;

    int          fail_count;
    int          pending_buckets;
    int          cycle_count;
    int          bytes_sent;
    int          burst_left;
    logic        hold_req;

    string_bucket_hash_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    sbh_bucket_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending_buckets)
    );

    // Clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Timeout
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: stall pattern in segments, plus one long hold-off on request
    initial begin
        int seg_left;
        int mode;
        seg_left   = 0;
        mode       = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
            end
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 2);
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            case (mode)
                0:       i_m_tready = 1'b1;
                1:       i_m_tready = $urandom_range(0, 1);
                default: i_m_tready = ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // One key word; sender runs in bursts with random gaps between them
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = b;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    // Mostly random characters, with the extremes now and then
    function automatic logic [7:0] random_key_char();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'hFF;
        if (pick == 1)
            return 8'h01;
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic send_random_key(input int max_len);
        int len;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            len = $urandom_range(0, 6);
        else if (pick < 95)
            len = $urandom_range(7, 20);
        else
            len = $urandom_range(21, 60);
        if (len > max_len)
            len = max_len;
        for (int i = 0; i < len; i++)
            send_byte(random_key_char());
        send_byte(KEY_END);
    endtask

    // Let every expected bucket arrive and the core go quiet
    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (pending_buckets != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_table_size(input logic [15:0] buckets);
        wait_drained();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = buckets;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        @(negedge i_clk);
    endtask

    // Empty key and a short key at a given bucket count
    task automatic probe_table_size(input logic [15:0] buckets);
        write_table_size(buckets);
        send_byte(KEY_END);
        send_byte(8'hFF);
        send_byte(KEY_END);
    endtask

    initial begin
        int phase;
        int phase_end;
        logic [15:0] buckets;

        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = 8'h00;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 16'h0000;
        hold_req      = 1'b0;
        bytes_sent    = 0;
        burst_left    = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed keys at the reset bucket count: empty key, single extremes,
        // a run of all-ones bytes to exercise the rotate, and plain text
        send_byte(KEY_END);
        send_byte(8'h01); send_byte(KEY_END);
        send_byte(8'hFF); send_byte(KEY_END);
        send_byte(8'h80); send_byte(KEY_END);
        repeat (5) send_byte(8'hFF);
        send_byte(KEY_END);
        send_byte("k"); send_byte("e"); send_byte("y"); send_byte(KEY_END);

        // Bucket count extremes, zero count included
        probe_table_size(16'd1);
        probe_table_size(16'hFFFF);
        probe_table_size(16'd0);

        // Random phases, each at its own bucket count
        bytes_sent = 0;
        phase      = 0;
        while (bytes_sent < RANDOM_ITEMS) begin
            case (phase % 6)
                0:       buckets = 16'($urandom_range(1, 65535));
                1:       buckets = 16'($urandom_range(1, 64));
                2:       buckets = 16'hFFFF;
                3:       buckets = 16'd1;
                4:       buckets = 16'd0;
                default: buckets = 16'($urandom_range(1000, 4000));
            endcase
            write_table_size(buckets);

            // Receiver holds off while short keys pile up behind it
            if (phase == 2) begin
                hold_req = 1'b1;
                repeat (12) send_random_key(2);
            end

            phase_end = bytes_sent + $urandom_range(150, 300);
            while (bytes_sent < phase_end && bytes_sent < RANDOM_ITEMS)
                send_random_key(60);
            phase++;
        end

        i_s_tvalid = 1'b0;
        while (pending_buckets != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (fail_count == 0 && pending_buckets == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
